[hw/rtl/pll_pkg.sv]
// Shared constants, command and status codes and the response record of the list editor.
`timescale 1ns / 1ps

package pll_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 12;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 12;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        list_length;
  } pll_rsp_t;

  typedef struct packed {
    logic link_we;
    logic elem_we;
  } pll_wr_en_t;

endpackage

[hw/rtl/pll_ifs.sv]
// Request and response channel interfaces of the list editor.
`timescale 1ns / 1ps

interface pll_req_if;
  import pll_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

interface pll_rsp_if;
  import pll_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [LEN_W-1:0]        list_length;

  modport source (output valid, read_value, status, list_length, input ready);
  modport sink (input valid, read_value, status, list_length, output ready);
endinterface

[hw/rtl/pll_store.sv]
// Node pool: link memory and element memory, one write and one shared read address.
`timescale 1ns / 1ps

module pll_store #(
  parameter int POOL_DEPTH = 4096,
  localparam int IDX_W = $clog2(POOL_DEPTH)
) (
  input  logic                       clk,
  input  pll_pkg::pll_wr_en_t        wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [IDX_W-1:0]           link_wdata,
  input  logic [pll_pkg::VAL_W-1:0]  elem_wdata,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [IDX_W-1:0]           link_q,
  output logic [pll_pkg::VAL_W-1:0]  elem_q
);
  import pll_pkg::*;

  logic [IDX_W-1:0] link_mem [POOL_DEPTH];
  logic [VAL_W-1:0] elem_mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    link_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en.elem_we) begin
      elem_mem[wr_addr] <= elem_wdata;
    end
    elem_q <= elem_mem[rd_addr];
  end

endmodule

[hw/rtl/pll_ctrl.sv]
// Command sequencer: range checks, link walk, node splice and unlink, counters.
`timescale 1ns / 1ps

module pll_ctrl #(
  parameter int POOL_DEPTH = 4096,
  localparam int IDX_W = $clog2(POOL_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [pll_pkg::CMD_W-1:0]         command,
  input  logic [pll_pkg::POS_W-1:0]         position,
  input  logic signed [pll_pkg::VAL_W-1:0]  value,
  input  logic                              res_free,
  output logic                              done,
  output pll_pkg::pll_rsp_t                 res,
  output pll_pkg::pll_wr_en_t               wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output logic [IDX_W-1:0]                  link_wdata,
  output logic [pll_pkg::VAL_W-1:0]         elem_wdata,
  output logic [IDX_W-1:0]                  rd_addr,
  input  logic [IDX_W-1:0]                  link_q,
  input  logic [pll_pkg::VAL_W-1:0]         elem_q
);
  import pll_pkg::*;

  localparam int CNT_W = IDX_W + 1;
  localparam int CW    = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_LINK1  = 3'd3;
  localparam logic [2:0] S_LINK2  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]              state;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        pos;
  logic [VAL_W-1:0]        val;
  logic [CNT_W-1:0]        alloc;
  logic [IDX_W-1:0]        length;
  logic [IDX_W-1:0]        cnt;
  logic [IDX_W-1:0]        cur;
  logic [IDX_W-1:0]        prev;
  logic [IDX_W-1:0]        succ;
  logic signed [VAL_W-1:0] rd_val;
  logic [ST_W-1:0]         status;

  logic             full;
  logic [CW-1:0]    pos_x;
  logic [CW-1:0]    len_x;
  logic             walk_end;
  logic [IDX_W-1:0] fresh;

  assign full     = (alloc == CNT_W'(POOL_DEPTH));
  assign pos_x    = CW'(pos);
  assign len_x    = CW'(length);
  assign walk_end = (cnt == '0);
  assign fresh    = alloc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      alloc  <= CNT_W'(1);
      length <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd   <= command;
            pos   <= position;
            val   <= value;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          rd_val <= '0;
          cur    <= '0;
          prev   <= '0;
          status <= ST_OK;
          state  <= S_FIN;
          case (cmd)
            CMD_CLEAR: begin
              alloc  <= CNT_W'(1);
              length <= '0;
            end
            CMD_APPEND: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                cnt   <= length;
                state <= S_WALK;
              end
            end
            CMD_INSERT: begin
              if (pos_x > len_x) begin
                status <= ST_RANGE;
              end else if (full) begin
                status <= ST_FULL;
              end else begin
                cnt   <= pos_x[IDX_W-1:0];
                state <= S_WALK;
              end
            end
            CMD_DELETE, CMD_READ: begin
              // walk one link past the predecessor to land on the target node
              if (pos_x >= len_x) begin
                status <= ST_RANGE;
              end else begin
                cnt   <= pos_x[IDX_W-1:0] + IDX_W'(1);
                state <= S_WALK;
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          if (!walk_end) begin
            cnt  <= cnt - IDX_W'(1);
            prev <= cur;
            cur  <= link_q;
          end else begin
            succ <= link_q;
            case (cmd)
              CMD_DELETE: begin
                length <= length - IDX_W'(1);
                state  <= S_FIN;
              end
              CMD_READ: begin
                rd_val <= elem_q;
                state  <= S_FIN;
              end
              default: state <= S_LINK1;
            endcase
          end
        end
        S_LINK1: state <= S_LINK2;
        S_LINK2: begin
          alloc  <= alloc + CNT_W'(1);
          length <= length + IDX_W'(1);
          state  <= S_FIN;
        end
        S_FIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);
  assign done      = (state == S_FIN) && res_free;

  always_comb begin
    res.read_value  = rd_val;
    res.status      = status;
    res.list_length = LEN_W'(length);
  end

  // memory port steering; reads follow the link register during a walk
  always_comb begin
    wr_en      = '0;
    wr_addr    = cur;
    link_wdata = succ;
    elem_wdata = val;
    rd_addr    = link_q;
    case (state)
      S_DECODE: begin
        rd_addr = '0;
        if (cmd == CMD_CLEAR) begin
          wr_en.link_we = 1'b1;
          wr_addr       = '0;
          link_wdata    = '0;
        end
      end
      S_WALK: begin
        if (walk_end && (cmd == CMD_DELETE)) begin
          wr_en.link_we = 1'b1;
          wr_addr       = prev;
          link_wdata    = link_q;
        end
      end
      S_LINK1: begin
        wr_en.link_we = 1'b1;
        wr_en.elem_we = 1'b1;
        wr_addr       = fresh;
        link_wdata    = succ;
      end
      S_LINK2: begin
        wr_en.link_we = 1'b1;
        wr_addr       = cur;
        link_wdata    = fresh;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_len_below_alloc: assert property (@(posedge clk) disable iff (rst)
    {1'b0, length} < alloc)
    else $error("list length not below pool allocation");

  a_alloc_bounds: assert property (@(posedge clk) disable iff (rst)
    (alloc != '0) && (alloc <= CNT_W'(POOL_DEPTH)))
    else $error("pool allocation out of bounds");

  a_no_splice_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK1) |-> !full)
    else $error("node splice with exhausted pool");

  a_walk_countdown: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !walk_end) |=> (state == S_WALK && cnt == $past(cnt) - IDX_W'(1)))
    else $error("walk step lost");

  a_alloc_bump: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK2) |=> (alloc == $past(alloc) + CNT_W'(1)))
    else $error("allocation counter not bumped after splice");
`endif

endmodule

[hw/rtl/pooled_linked_list_editor_core.sv]
// Top level of the pooled linked-list editor: sequencer, node pool and response register.
//
//   channel | dir | fields                                 | accepted when
//   req     | in  | command, position, value               | req.valid && req.ready
//   rsp     | out | read_value, status, list_length        | rsp.valid && rsp.ready
//
// Sequencing: one request at a time. Each request passes through decode and then
//   the finish state; append and insert walk and splice (LINK1, LINK2) in between,
//   delete and read only walk. Clear, unused codes and rejected requests skip the
//   walk. The walk covers the list length in links for append, the position for
//   insert and position + 1 for delete and read, and follows one link per cycle
//   through the link memory read port.
// Reset: clears the sequencer, the allocation counter (head sentinel taken) and
//   the length; the pool memories are not cleared and need no sweep.
// Stalls: a finished response waits in the output register; the next request is
//   accepted meanwhile and stalls only when its own response is ready to load.
`timescale 1ns / 1ps

module pooled_linked_list_editor_core #(
  parameter int POOL_DEPTH = 4096
) (
  input logic       clk,
  input logic       rst,
  pll_req_if.sink   req,
  pll_rsp_if.source rsp
);
  import pll_pkg::*;

  localparam int IDX_W = $clog2(POOL_DEPTH);

  // sequencer <-> pool
  pll_wr_en_t       wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] link_wdata;
  logic [VAL_W-1:0] elem_wdata;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] link_q;
  logic [VAL_W-1:0] elem_q;

  // sequencer <-> response register
  logic     res_free;
  logic     done;
  pll_rsp_t res;

  logic     rsp_valid;
  pll_rsp_t rsp_data;

  pll_ctrl #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .command    (req.command),
    .position   (req.position),
    .value      (req.value),
    .res_free   (res_free),
    .done       (done),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .link_wdata (link_wdata),
    .elem_wdata (elem_wdata),
    .rd_addr    (rd_addr),
    .link_q     (link_q),
    .elem_q     (elem_q)
  );

  pll_store #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .link_wdata (link_wdata),
    .elem_wdata (elem_wdata),
    .rd_addr    (rd_addr),
    .link_q     (link_q),
    .elem_q     (elem_q)
  );

  // response register: free when empty or being drained this cycle
  assign res_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.read_value  = rsp_data.read_value;
  assign rsp.status      = rsp_data.status;
  assign rsp.list_length = rsp_data.list_length;

endmodule
